// ===== rtl/mlpfb_pkg.sv =====
package mlpfb_pkg;

  localparam int MaxPanelsDef = 4;
  localparam int PanelRows    = 16;
  localparam int PanelCols    = 32;
  localparam int ColBytes     = PanelCols / 8;

  localparam logic [7:0] StoreResetByte = 8'hFF;
  localparam logic [7:0] PixelMsbMask   = 8'h80;

  typedef enum logic [1:0] {
    CMD_PIXEL = 2'd0,
    CMD_SHIFT = 2'd1,
    CMD_SCAN  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_PANELS_WIDE = 2'd0,
    REG_PANELS_HIGH = 2'd1,
    REG_INVERT_ALL  = 2'd2,
    REG_DRAW_MODE   = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PIX,
    ST_SH_LOAD,
    ST_SH_RUN,
    ST_SCAN,
    ST_ACK
  } state_e;

  typedef struct packed {
    logic rd;
    logic wr;
  } mem_ctl_t;

endpackage

// ===== rtl/mlpfb_if.sv =====
interface mlpfb_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic [6:0]        pos_x;
  logic [5:0]        pos_y;
  logic              color;
  logic signed [1:0] shift_step;

  modport source (output valid, command, pos_x, pos_y, color, shift_step, input ready);
  modport sink   (input valid, command, pos_x, pos_y, color, shift_step, output ready);
endinterface

interface mlpfb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] scan_group;
  logic       last;

  modport source (output valid, out_byte, scan_group, last, input ready);
  modport sink   (input valid, out_byte, scan_group, last, output ready);
endinterface

// ===== rtl/mono_led_panel_frame_buffer.sv =====
// Frame buffer for chained 32x16 monochrome LED panels, one bit per pixel,
// a zero bit meaning the pixel is lit.
// Commands arrive on item_i (valid/ready); a word is taken when both are
// high, and only while the sequencer is idle. Results leave on result_o
// from an output register, so a stalled receiver only holds that register;
// the sequencer waits for it before loading the next result.
// Pixel write: one read-modify-write of a byte, then the acknowledge word;
// a pixel off the screen is acknowledged without touching the store.
// Shift: one byte per cycle through the buffer, then the acknowledge word.
// Scan: 16 * total_panels data words, one per cycle while the receiver
// keeps up; the last word has last set and the row group counter then
// advances.
// The store is a single memory with one read and one write port and a
// registered read; it sets the pace of every command. The user must write
// configuration through cfg_we_i/cfg_idx_i/cfg_wdata_i only while idle;
// the block does not enforce it. Reset clears the registers, the row group
// counter and the per-byte valid flags, so all pixels read as off at once.
module mono_led_panel_frame_buffer #(
  parameter int MAX_PANELS = mlpfb_pkg::MaxPanelsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mlpfb_in_if.sink    item_i,
  mlpfb_out_if.source result_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [2:0]  cfg_wdata_i
);
  import mlpfb_pkg::*;

  localparam int RowBytesMax = MAX_PANELS * ColBytes;
  localparam int StoreBytes  = RowBytesMax * PanelRows;
  localparam int AW          = $clog2(StoreBytes);
  localparam int RW          = $clog2(RowBytesMax + 1);
  localparam int IW          = $clog2(RowBytesMax);
  localparam int PW          = $clog2(MAX_PANELS + 1);

  // Configuration
  logic [2:0] pw_q, ph_q;
  logic       inv_q, mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pw_q   <= 3'd1;
      ph_q   <= 3'd1;
      inv_q  <= 1'b0;
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_PANELS_WIDE: pw_q   <= cfg_wdata_i;
        REG_PANELS_HIGH: ph_q   <= cfg_wdata_i;
        REG_INVERT_ALL:  inv_q  <= cfg_wdata_i[0];
        REG_DRAW_MODE:   mode_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  logic [2:0]    pw_eff, ph_eff;
  logic [5:0]    prod;
  logic [PW-1:0] tot;
  logic [RW-1:0] rowsize;
  logic [AW-1:0] last_pos;

  assign pw_eff   = (pw_q == 3'd0) ? 3'd1 : pw_q;
  assign ph_eff   = (ph_q == 3'd0) ? 3'd1 : ph_q;
  assign prod     = 6'(pw_eff * ph_eff);
  assign tot      = (prod > 6'(MAX_PANELS)) ? PW'(MAX_PANELS) : PW'(prod);
  assign rowsize  = RW'(tot * ColBytes);
  assign last_pos = AW'(rowsize * PanelRows - 1);

  // Pixel address, from the incoming word
  logic [7:0]  x_lim;
  logic [6:0]  y_lim;
  logic [9:0]  bx;
  logic [6:0]  colb;
  logic [10:0] pix_ptr;
  logic        pix_hit;

  assign x_lim   = 8'(pw_eff * PanelCols);
  assign y_lim   = 7'(ph_eff * PanelRows);
  assign bx      = 10'(item_i.pos_x) + 10'(x_lim) * 10'(item_i.pos_y[5:4]);
  assign colb    = bx[9:3];
  assign pix_ptr = 11'(colb) + 11'(item_i.pos_y[3:0]) * 11'(rowsize);
  assign pix_hit = (8'(item_i.pos_x) < x_lim) && (7'(item_i.pos_y) < y_lim)
                   && (8'(colb) < 8'(rowsize));

  // Sequencer state
  state_e        state_q, state_d;
  logic [1:0]    grp_q, grp_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic [7:0]    mask_q, mask_d;
  logic          bit_q, bit_d;
  logic          left_q, left_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [IW-1:0] col_q, col_d;
  logic [7:0]    cur_q, cur_d;
  logic [IW-1:0] si_q, si_d;
  logic [1:0]    sk_q, sk_d;

  logic          out_valid_q;
  logic [7:0]    out_byte_q, out_byte_d;
  logic [1:0]    out_grp_q, out_grp_d;
  logic          out_last_q, out_last_d;
  logic          out_load, out_free;

  mem_ctl_t      mem_ctl;
  logic [AW-1:0] raddr, waddr;
  logic [7:0]    wdata, rdata;

  logic          acc;
  logic          sh_last, sh_edge, sh_in;
  logic          scan_last;
  logic [IW-1:0] si_n;
  logic [1:0]    sk_n;
  logic [3:0]    scan_row;

  assign item_i.ready = (state_q == ST_IDLE);
  assign acc          = item_i.valid && item_i.ready;
  assign out_free     = !out_valid_q || result_o.ready;

  assign sh_last   = left_q ? (pos_q == last_pos) : (pos_q == '0);
  assign sh_edge   = left_q ? (col_q == IW'(rowsize - 1'b1)) : (col_q == '0);
  assign sh_in     = sh_edge ? ~inv_q : (left_q ? rdata[7] : rdata[0]);
  assign scan_last = (si_q == IW'(rowsize - 1'b1)) && (sk_q == 2'd3);
  assign sk_n      = sk_q + 2'd1;
  assign si_n      = (sk_q == 2'd3) ? si_q + 1'b1 : si_q;
  // Rows g+12, g+8, g+4, g in turn.
  assign scan_row  = {2'd3 - sk_n, grp_q};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          unique case (cmd_e'(item_i.command))
            CMD_PIXEL: state_d = pix_hit ? ST_PIX : ST_ACK;
            CMD_SHIFT: state_d = (item_i.shift_step == 2'sd0) ? ST_ACK : ST_SH_LOAD;
            CMD_SCAN:  state_d = ST_SCAN;
            default:   state_d = ST_ACK;
          endcase
        end
      end
      ST_PIX:     state_d = ST_ACK;
      ST_SH_LOAD: state_d = ST_SH_RUN;
      ST_SH_RUN:  if (sh_last) state_d = ST_ACK;
      ST_SCAN:    if (out_free && scan_last) state_d = ST_IDLE;
      ST_ACK:     if (out_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_ctl    = '0;
    raddr      = '0;
    waddr      = ptr_q;
    wdata      = rdata;
    out_load   = 1'b0;
    out_byte_d = 8'd0;
    out_grp_d  = grp_q;
    out_last_d = 1'b1;
    grp_d      = grp_q;
    ptr_d      = ptr_q;
    mask_d     = mask_q;
    bit_d      = bit_q;
    left_d     = left_q;
    pos_d      = pos_q;
    col_d      = col_q;
    cur_d      = cur_q;
    si_d       = si_q;
    sk_d       = sk_q;
    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          unique case (cmd_e'(item_i.command))
            CMD_PIXEL: begin
              ptr_d       = pix_ptr[AW-1:0];
              mask_d      = PixelMsbMask >> bx[2:0];
              bit_d       = item_i.color ^ inv_q;
              mem_ctl.rd  = pix_hit;
              raddr       = pix_ptr[AW-1:0];
            end
            CMD_SHIFT: begin
              left_d     = item_i.shift_step[1];
              pos_d      = item_i.shift_step[1] ? '0 : last_pos;
              col_d      = item_i.shift_step[1] ? '0 : IW'(rowsize - 1'b1);
              mem_ctl.rd = 1'b1;
              raddr      = item_i.shift_step[1] ? '0 : last_pos;
            end
            CMD_SCAN: begin
              si_d       = '0;
              sk_d       = '0;
              mem_ctl.rd = 1'b1;
              raddr      = AW'(rowsize * {2'd3, grp_q});
            end
            default: ;
          endcase
        end
      end
      ST_PIX: begin
        mem_ctl.wr = 1'b1;
        if (!mode_q) begin
          wdata = bit_q ? (rdata & ~mask_q) : (rdata | mask_q);
        end else if (bit_q && ((rdata & mask_q) == 8'd0)) begin
          wdata = rdata | mask_q;
        end
      end
      ST_SH_LOAD: begin
        cur_d      = rdata;
        mem_ctl.rd = 1'b1;
        raddr      = left_q ? pos_q + 1'b1 : pos_q - 1'b1;
      end
      ST_SH_RUN: begin
        // Write the current byte while the neighbor of the next one is read.
        mem_ctl.wr = 1'b1;
        waddr      = pos_q;
        wdata      = left_q ? {cur_q[6:0], sh_in} : {sh_in, cur_q[7:1]};
        cur_d      = rdata;
        if (!sh_last) begin
          if (left_q) begin
            pos_d      = pos_q + 1'b1;
            col_d      = sh_edge ? '0 : col_q + 1'b1;
            mem_ctl.rd = (pos_q + 1'b1) != last_pos;
            raddr      = pos_q + AW'(2);
          end else begin
            pos_d      = pos_q - 1'b1;
            col_d      = sh_edge ? IW'(rowsize - 1'b1) : col_q - 1'b1;
            mem_ctl.rd = (pos_q - 1'b1) != '0;
            raddr      = pos_q - AW'(2);
          end
        end
      end
      ST_SCAN: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_byte_d = rdata;
          out_last_d = scan_last;
          if (scan_last) begin
            grp_d = grp_q + 2'd1;
          end else begin
            si_d       = si_n;
            sk_d       = sk_n;
            mem_ctl.rd = 1'b1;
            raddr      = AW'(rowsize * scan_row + si_n);
          end
        end
      end
      ST_ACK: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      grp_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      grp_q   <= grp_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q  <= ptr_d;
    mask_q <= mask_d;
    bit_q  <= bit_d;
    left_q <= left_d;
    pos_q  <= pos_d;
    col_q  <= col_d;
    cur_q  <= cur_d;
    si_q   <= si_d;
    sk_q   <= sk_d;
    if (out_load) begin
      out_byte_q <= out_byte_d;
      out_grp_q  <= out_grp_d;
      out_last_q <= out_last_d;
    end
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.out_byte   = out_byte_q;
  assign result_o.scan_group = out_grp_q;
  assign result_o.last       = out_last_q;

  mlpfb_mem #(
    .Depth (StoreBytes)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (mem_ctl),
    .raddr_i (raddr),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("result register loaded while a word is still pending");

  a_rw_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_ctl.rd && mem_ctl.wr) |-> (raddr != waddr))
    else $error("read and write of the same byte in one cycle");

  a_pix_read_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PIX) |-> $past(mem_ctl.rd))
    else $error("pixel update without a preceding read");

  a_grp_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && out_load && scan_last) |=> (grp_q == $past(grp_q) + 2'd1))
    else $error("row group counter did not advance after a scan");

  a_idle_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && out_load && scan_last) |=> (state_q == ST_IDLE))
    else $error("sequencer kept scanning past the last byte");

endmodule

// ===== rtl/mlpfb_mem.sv =====
module mlpfb_mem #(
  parameter int Depth = 256,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mlpfb_pkg::mem_ctl_t ctl_i,
  input  logic [AddrW-1:0]    raddr_i,
  input  logic [AddrW-1:0]    waddr_i,
  input  logic [7:0]          wdata_i,
  output logic [7:0]          rdata_o
);
  import mlpfb_pkg::*;

  logic [7:0]       mem [Depth];
  logic [Depth-1:0] valid_q;
  logic [7:0]       rdata_q;
  logic             rvalid_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      mem[waddr_i] <= wdata_i;
    end
    if (ctl_i.rd) begin
      rdata_q <= mem[raddr_i];
    end
  end

  // An entry that was not written since reset reads as the reset pattern.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (ctl_i.wr) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (ctl_i.rd) begin
        rvalid_q <= valid_q[raddr_i];
      end
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : StoreResetByte;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import mlpfb_pkg::*;

  localparam int QuietLimit  = 5000;
  localparam int PhaseItems  = 17;
  localparam int StoreBytes  = MaxPanelsDef * ColBytes * PanelRows;
  localparam int ReportLimit = 100;

  typedef struct packed {
    cmd_e              command;
    logic [6:0]        pos_x;
    logic [5:0]        pos_y;
    logic              color;
    logic signed [1:0] shift_step;
  } command_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] scan_group;
    logic       last;
  } panel_word_t;

  class frame_scoreboard;
    logic [7:0]  frame_mem [StoreBytes];
    logic [1:0]  group_cnt;
    logic [2:0]  wide_q;
    logic [2:0]  high_q;
    logic        invert_q;
    logic        nor_q;
    panel_word_t expected_q [$];
    int          errors;
    int          words_checked;
    int          commands_noted;
    int          scans_noted;

    function new();
      foreach (frame_mem[i]) frame_mem[i] = StoreResetByte;
      group_cnt      = 2'd0;
      wide_q         = 3'd1;
      high_q         = 3'd1;
      invert_q       = 1'b0;
      nor_q          = 1'b0;
      errors         = 0;
      words_checked  = 0;
      commands_noted = 0;
      scans_noted    = 0;
    endfunction

    function void set_register(reg_idx_e idx, logic [2:0] value);
      case (idx)
        REG_PANELS_WIDE: wide_q = value;
        REG_PANELS_HIGH: high_q = value;
        REG_INVERT_ALL:  invert_q = value[0];
        REG_DRAW_MODE:   nor_q = value[0];
      endcase
    endfunction

    // A panel count of zero behaves as one panel.
    function int count_of(logic [2:0] v);
      return (v == 3'd0) ? 1 : int'(v);
    endfunction

    function int row_bytes();
      int t;
      t = count_of(wide_q) * count_of(high_q);
      return ColBytes * ((t > MaxPanelsDef) ? MaxPanelsDef : t);
    endfunction

    function void report(string msg);
      errors++;
      // Only the first hundred are printed.
      if (errors <= ReportLimit) $display("MISMATCH: %s", msg);
    endfunction

    function void note_command(command_word_t w);
      int          rb;
      int          pw;
      int          ph;
      int          bx;
      int          ptr;
      int          n;
      int          i;
      int          k;
      int          idx;
      logic [7:0]  mask;
      logic        on;
      logic        fill;
      panel_word_t r;
      rb   = row_bytes();
      pw   = count_of(wide_q);
      ph   = count_of(high_q);
      n    = rb * PanelRows;
      fill = ~invert_q;
      commands_noted++;
      case (w.command)
        CMD_PIXEL: begin
          // Panels stacked downward continue to the right of the top row of panels.
          bx = int'(w.pos_x) + pw * PanelCols * (int'(w.pos_y) / PanelRows);
          if (int'(w.pos_x) < pw * PanelCols && int'(w.pos_y) < ph * PanelRows &&
              (bx >> 3) < rb) begin
            ptr  = (bx >> 3) + (int'(w.pos_y) % PanelRows) * rb;
            mask = PixelMsbMask >> (bx & 7);
            on   = w.color ^ invert_q;
            if (!nor_q) begin
              if (on) frame_mem[ptr] &= ~mask;
              else frame_mem[ptr] |= mask;
            end else if (on && (frame_mem[ptr] & mask) == 8'h00) begin
              frame_mem[ptr] |= mask;
            end
          end
        end
        CMD_SHIFT: begin
          if (w.shift_step[1]) begin
            for (i = 0; i < n; i++)
              frame_mem[i] = {frame_mem[i][6:0],
                              (i % rb == rb - 1) ? fill : frame_mem[i + 1][7]};
          end else if (w.shift_step[0]) begin
            for (i = n - 1; i >= 0; i--)
              frame_mem[i] = {(i % rb == 0) ? fill : frame_mem[i - 1][0],
                              frame_mem[i][7:1]};
          end
        end
        CMD_SCAN: begin
          scans_noted++;
          // Each column byte goes out for rows g+12, g+8, g+4 and g in turn.
          for (i = 0; i < rb; i++) begin
            for (k = 3; k >= 0; k--) begin
              idx          = rb * int'(group_cnt) + i + 4 * k * rb;
              r.out_byte   = frame_mem[idx % StoreBytes];
              r.scan_group = group_cnt;
              r.last       = (i == rb - 1) && (k == 0);
              expected_q.push_back(r);
            end
          end
          group_cnt = group_cnt + 2'd1;
        end
        default: ;
      endcase
      if (w.command != CMD_SCAN) begin
        r.out_byte   = 8'h00;
        r.scan_group = group_cnt;
        r.last       = 1'b1;
        expected_q.push_back(r);
      end
    endfunction

    function void check_word(panel_word_t got);
      panel_word_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected word out_byte=%02h scan_group=%0d last=%0d",
                         got.out_byte, got.scan_group, got.last));
        return;
      end
      want = expected_q.pop_front();
      words_checked++;
      if (got.out_byte !== want.out_byte)
        report($sformatf("word %0d: out_byte %02h, expected %02h",
                         words_checked, got.out_byte, want.out_byte));
      if (got.scan_group !== want.scan_group)
        report($sformatf("word %0d: scan_group %0d, expected %0d",
                         words_checked, got.scan_group, want.scan_group));
      if (got.last !== want.last)
        report($sformatf("word %0d: last %0d, expected %0d",
                         words_checked, got.last, want.last));
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic       cfg_we;
  reg_idx_e   cfg_idx;
  logic [2:0] cfg_wdata;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int quiet_cycles  = 0;
  int settings_run  = 0;

  frame_scoreboard sb = new();

  mlpfb_in_if  item_if ();
  mlpfb_out_if result_if ();

  mono_led_panel_frame_buffer DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item_if),
    .result_o   (result_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    result_if.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      quiet_cycles = quiet_cycles + 1;
      if (item_if.valid && item_if.ready) begin
        sb.note_command('{command:    cmd_e'(item_if.command),
                          pos_x:      item_if.pos_x,
                          pos_y:      item_if.pos_y,
                          color:      item_if.color,
                          shift_step: item_if.shift_step});
        quiet_cycles = 0;
      end
      if (result_if.valid && result_if.ready) begin
        sb.check_word('{out_byte:   result_if.out_byte,
                        scan_group: result_if.scan_group,
                        last:       result_if.last});
        quiet_cycles = 0;
      end
    end
  end

  initial begin
    wait (quiet_cycles >= QuietLimit);
    $display("testbench NOT OK");
    $finish;
  end

  function automatic command_word_t make_word(cmd_e c, logic [6:0] x, logic [5:0] y,
                                              logic col, logic signed [1:0] step);
    command_word_t w;
    w.command    = c;
    w.pos_x      = x;
    w.pos_y      = y;
    w.color      = col;
    w.shift_step = step;
    return w;
  endfunction

  function automatic command_word_t random_word(logic [2:0] wide, logic [2:0] high);
    command_word_t w;
    int            pw;
    int            ph;
    int            pick;
    pw           = (wide == 3'd0) ? 1 : int'(wide);
    ph           = (high == 3'd0) ? 1 : int'(high);
    w.pos_x      = 7'($urandom);
    w.pos_y      = 6'($urandom);
    w.color      = 1'($urandom);
    w.shift_step = 2'($urandom);
    pick         = int'($urandom_range(0, 99));
    if (pick < 55) begin
      w.command = CMD_PIXEL;
      // Most writes land on the configured screen; the rest may fall off it.
      if ($urandom_range(0, 9) != 0) begin
        w.pos_x = 7'($urandom_range(0, (pw * PanelCols > 128) ? 127 : pw * PanelCols - 1));
        w.pos_y = 6'($urandom_range(0, (ph * PanelRows > 64) ? 63 : ph * PanelRows - 1));
      end
    end else if (pick < 70) begin
      w.command = CMD_SHIFT;
    end else if (pick < 95) begin
      w.command = CMD_SCAN;
    end else begin
      w.command = CMD_NONE;
    end
    return w;
  endfunction

  task automatic write_register(reg_idx_e idx, logic [2:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    sb.set_register(idx, value);
    @(posedge clk_i);
  endtask

  task automatic send_word(command_word_t w, bit hold_off);
    if (hold_off) begin
      item_if.valid <= 1'b0;
      @(posedge clk_i);
      while (sb.expected_q.size() != 0) @(posedge clk_i);
    end
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_if.valid      <= 1'b1;
    item_if.command    <= w.command;
    item_if.pos_x      <= w.pos_x;
    item_if.pos_y      <= w.pos_y;
    item_if.color      <= w.color;
    item_if.shift_step <= w.shift_step;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
  endtask

  task automatic drain();
    item_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic run_phase(logic [2:0] wide, logic [2:0] high, logic inv,
                           logic nor_mode, int sidle, int rstall);
    int n;
    send_idle_pct = sidle;
    stall_pct     = rstall;
    write_register(REG_PANELS_WIDE, wide);
    write_register(REG_PANELS_HIGH, high);
    write_register(REG_INVERT_ALL, {2'b00, inv});
    write_register(REG_DRAW_MODE, {2'b00, nor_mode});
    for (n = 0; n < PhaseItems; n++)
      send_word(random_word(wide, high),
                (n == PhaseItems / 2) || ($urandom_range(0, 29) == 0));
    drain();
    settings_run++;
  endtask

  initial begin
    item_if.valid      <= 1'b0;
    item_if.command    <= CMD_PIXEL;
    item_if.pos_x      <= '0;
    item_if.pos_y      <= '0;
    item_if.color      <= 1'b0;
    item_if.shift_step <= '0;
    cfg_we             <= 1'b0;
    cfg_idx            <= REG_PANELS_WIDE;
    cfg_wdata          <= 3'd0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed pass on the reset settings of one 32x16 panel.
    send_word(make_word(CMD_SCAN, 7'd0, 6'd0, 1'b0, 2'sd0), 1'b0);
    send_word(make_word(CMD_PIXEL, 7'd0, 6'd0, 1'b1, 2'sd0), 1'b0);
    send_word(make_word(CMD_PIXEL, 7'd31, 6'd15, 1'b1, 2'sd0), 1'b0);
    send_word(make_word(CMD_PIXEL, 7'd127, 6'd63, 1'b1, 2'sd0), 1'b0);
    send_word(make_word(CMD_PIXEL, 7'd32, 6'd0, 1'b1, 2'sd0), 1'b0);
    send_word(make_word(CMD_PIXEL, 7'd5, 6'd16, 1'b1, 2'sd0), 1'b0);
    send_word(make_word(CMD_PIXEL, 7'd8, 6'd3, 1'b1, 2'sd0), 1'b0);
    send_word(make_word(CMD_PIXEL, 7'd17, 6'd7, 1'b1, 2'sd0), 1'b0);
    send_word(make_word(CMD_PIXEL, 7'd31, 6'd15, 1'b0, 2'sd0), 1'b0);
    send_word(make_word(CMD_SCAN, 7'd0, 6'd0, 1'b0, 2'sd0), 1'b0);
    send_word(make_word(CMD_SHIFT, 7'd0, 6'd0, 1'b0, 2'sd1), 1'b0);
    send_word(make_word(CMD_SHIFT, 7'd0, 6'd0, 1'b0, -2'sd1), 1'b0);
    send_word(make_word(CMD_SHIFT, 7'd0, 6'd0, 1'b0, -2'sd2), 1'b0);
    send_word(make_word(CMD_SHIFT, 7'd127, 6'd63, 1'b1, 2'sd0), 1'b0);
    send_word(make_word(CMD_NONE, 7'd127, 6'd63, 1'b1, 2'sd1), 1'b0);
    send_word(make_word(CMD_PIXEL, 7'd0, 6'd12, 1'b1, 2'sd0), 1'b0);
    send_word(make_word(CMD_SCAN, 7'd127, 6'd63, 1'b1, -2'sd1), 1'b0);
    send_word(make_word(CMD_SCAN, 7'd0, 6'd0, 1'b0, 2'sd0), 1'b0);
    send_word(make_word(CMD_SCAN, 7'd0, 6'd0, 1'b0, 2'sd0), 1'b0);
    send_word(make_word(CMD_PIXEL, 7'd7, 6'd0, 1'b0, 2'sd0), 1'b0);
    send_word(make_word(CMD_SCAN, 7'd0, 6'd0, 1'b0, 2'sd0), 1'b0);
    drain();
    settings_run = 1;

    run_phase(3'd4, 3'd1, 1'b0, 1'b0, 0, 0);
    run_phase(3'd2, 3'd2, 1'b1, 1'b0, 46, 0);
    run_phase(3'd1, 3'd4, 1'b0, 1'b1, 0, 46);
    run_phase(3'd7, 3'd7, 1'b1, 1'b1, 22, 22);
    run_phase(3'd0, 3'd0, 1'b0, 1'b0, 46, 0);
    run_phase(3'd1, 3'd1, 1'b1, 1'b1, 0, 46);
    run_phase(3'd3, 3'd1, 1'b0, 1'b1, 22, 22);
    run_phase(3'd4, 3'd4, 1'b0, 1'b0, 0, 0);

    if (sb.expected_q.size() != 0)
      sb.report($sformatf("%0d expected words never arrived", sb.expected_q.size()));
    $display("Sent %0d commands, %0d of them scans, under %0d register settings.",
             sb.commands_noted, sb.scans_noted, settings_run);
    $display("Compared %0d result words with sender gaps and receiver stalls mixed in.",
             sb.words_checked);
    if (sb.errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/mlpfb_pkg.sv
rtl/mlpfb_if.sv
rtl/mlpfb_mem.sv
rtl/mono_led_panel_frame_buffer.sv
tb/testbench.sv
